/* rtl/core/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, latencies and types for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int AXIS_FRAC = 30;                      // Q2.30 axis components
  localparam int MANT_W    = 30;                      // normalized magnitude width
  localparam int SQ_W      = 2 * MANT_W;              // one squared magnitude
  localparam int SUMSQ_W   = SQ_W + 2;                // sum of three squares
  localparam int ROOT_W    = SUMSQ_W / 2;             // floor(sqrt) width
  localparam int QUO_W     = ROOT_W;                  // quotient width, q <= 2^30
  localparam int NUM_W     = MANT_W + AXIS_FRAC + 1;  // dividend width
  localparam int SQRT_LAT  = ROOT_W;                  // one root bit per stage
  localparam int DIV_LAT   = QUO_W;                   // one quotient bit per stage
  localparam int NORM_LAT  = 7 + SQRT_LAT + 1 + DIV_LAT + 1;

  localparam logic [63:0] HALF_LSB = 64'(1) << (AXIS_FRAC - 1);

  typedef logic [2:0][31:0] vec3_t;

endpackage

/* rtl/core/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point look-at camera matrix: rotation rows and translations.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while not stalled (eye, target and up hint
// in signed Q16.16) and returns one per accepted transaction. The latency is
// set by the two normalizers (forward axis, then right axis), each 71 stages
// long because of a 31-stage square root and a 31-stage divider. Outputs are
// the right, true up and back rows in Q2.30 and the three translations in
// Q16.16, rounded half away from zero and saturated. A zero forward vector
// zeroes all rows, a zero right vector the right and true up rows. While
// out_valid, out_stall freezes the pipeline; in_stall follows it directly.
// ----------------------------------------------------------------------------
module look_at_view_matrix
  import lav_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_aim_x,
  input  logic signed [31:0] in_aim_y,
  input  logic signed [31:0] in_aim_z,
  input  logic signed [31:0] in_upward_x,
  input  logic signed [31:0] in_upward_y,
  input  logic signed [31:0] in_upward_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_right_x,
  output logic signed [31:0] out_right_y,
  output logic signed [31:0] out_right_z,
  output logic signed [31:0] out_true_up_x,
  output logic signed [31:0] out_true_up_y,
  output logic signed [31:0] out_true_up_z,
  output logic signed [31:0] out_back_x,
  output logic signed [31:0] out_back_y,
  output logic signed [31:0] out_back_z,
  output logic signed [31:0] out_shift_right,
  output logic signed [31:0] out_shift_up,
  output logic signed [31:0] out_shift_back
);

  logic en;

  logic v0_r, v1_r, v73_r, v74_r, v146_r, v147_r, v148_r, v149_r;
  logic v150_r, v151_r, v152_r, v153_r;
  logic v72, v145;

  vec3_t             e0_r, a0_r, u0_r;
  vec3_t             e1_r, u1_r;
  logic [2:0][32:0]  d1_r;
  vec3_t             f72, e72, u72;
  logic signed [63:0] p73_r [6];
  vec3_t             f73_r, e73_r;
  logic [2:0][63:0]  c74_r;
  vec3_t             f74_r, e74_r;
  vec3_t             r145, f145, e145;
  logic signed [63:0] q146_r [6];
  vec3_t             r146_r, f146_r, e146_r;
  logic signed [63:0] x147_r [3];
  vec3_t             r147_r, f147_r, e147_r;
  logic [2:0][61:0]  mag148_r;
  logic [2:0]        sgn148_r;
  vec3_t             r148_r, f148_r, e148_r;
  logic [2:0][32:0]  t149_r;
  vec3_t             r149_r, b149_r, e149_r;
  logic signed [63:0] dp150_r [9];
  vec3_t             r150_r, t150_r, b150_r;
  logic signed [63:0] dsum151_r [3];
  vec3_t             r151_r, t151_r, b151_r;
  logic [2:0][62:0]  dmag152_r;
  logic [2:0]        dsgn152_r;
  vec3_t             r152_r, t152_r, b152_r;
  vec3_t             sh153_r, r153_r, t153_r, b153_r;

  logic [2:0][62:0]  rsum_c;
  logic [2:0][32:0]  rt_c;
  logic signed [32:0] ax_c [9];
  logic [2:0][63:0]  dsum_c;
  logic [2:0][33:0]  dr_c;
  vec3_t             sh_c;

  // freeze everything while a finished transaction is held at the output
  assign en       = ~(v153_r & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v73_r  <= 1'b0;
      v74_r  <= 1'b0;
      v146_r <= 1'b0;
      v147_r <= 1'b0;
      v148_r <= 1'b0;
      v149_r <= 1'b0;
      v150_r <= 1'b0;
      v151_r <= 1'b0;
      v152_r <= 1'b0;
      v153_r <= 1'b0;
    end else if (en) begin
      v0_r   <= in_valid;
      v1_r   <= v0_r;
      v73_r  <= v72;
      v74_r  <= v73_r;
      v146_r <= v145;
      v147_r <= v146_r;
      v148_r <= v147_r;
      v149_r <= v148_r;
      v150_r <= v149_r;
      v151_r <= v150_r;
      v152_r <= v151_r;
      v153_r <= v152_r;
    end
  end

  // rounded right shift by 30 of the r x f magnitudes, sign restored
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum_c[i] = 63'(mag148_r[i]) + 63'(HALF_LSB);
      rt_c[i]   = sgn148_r[i] ? -{1'b0, rsum_c[i][61:AXIS_FRAC]}
                              :  {1'b0, rsum_c[i][61:AXIS_FRAC]};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax_c[k]     = 33'($signed(r149_r[k]));
      ax_c[3 + k] = $signed(t149_r[k]);
      ax_c[6 + k] = 33'($signed(b149_r[k]));
    end
  end

  // round, negate and saturate the dot products
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dsum_c[a] = {1'b0, dmag152_r[a]} + HALF_LSB;
      dr_c[a]   = dsum_c[a][63:AXIS_FRAC];
      if (dsgn152_r[a]) begin
        if (dr_c[a] > 34'h07FFFFFFF) sh_c[a] = 32'h7FFFFFFF;
        else                         sh_c[a] = dr_c[a][31:0];
      end else begin
        if (dr_c[a] > 34'h080000000) sh_c[a] = 32'h80000000;
        else                         sh_c[a] = -dr_c[a][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r <= {in_eye_z, in_eye_y, in_eye_x};
      a0_r <= {in_aim_z, in_aim_y, in_aim_x};
      u0_r <= {in_upward_z, in_upward_y, in_upward_x};

      e1_r <= e0_r;
      u1_r <= u0_r;
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= {a0_r[i][31], a0_r[i]} - {e0_r[i][31], e0_r[i]};
      end

      // forward x up
      p73_r[0] <= $signed(f72[1]) * $signed(u72[2]);
      p73_r[1] <= $signed(f72[2]) * $signed(u72[1]);
      p73_r[2] <= $signed(f72[2]) * $signed(u72[0]);
      p73_r[3] <= $signed(f72[0]) * $signed(u72[2]);
      p73_r[4] <= $signed(f72[0]) * $signed(u72[1]);
      p73_r[5] <= $signed(f72[1]) * $signed(u72[0]);
      f73_r    <= f72;
      e73_r    <= e72;

      for (int i = 0; i < 3; i++) c74_r[i] <= p73_r[2*i] - p73_r[2*i + 1];
      f74_r <= f73_r;
      e74_r <= e73_r;

      // right x forward
      q146_r[0] <= $signed(r145[1]) * $signed(f145[2]);
      q146_r[1] <= $signed(r145[2]) * $signed(f145[1]);
      q146_r[2] <= $signed(r145[2]) * $signed(f145[0]);
      q146_r[3] <= $signed(r145[0]) * $signed(f145[2]);
      q146_r[4] <= $signed(r145[0]) * $signed(f145[1]);
      q146_r[5] <= $signed(r145[1]) * $signed(f145[0]);
      r146_r    <= r145;
      f146_r    <= f145;
      e146_r    <= e145;

      for (int i = 0; i < 3; i++) x147_r[i] <= q146_r[2*i] - q146_r[2*i + 1];
      r147_r <= r146_r;
      f147_r <= f146_r;
      e147_r <= e146_r;

      for (int i = 0; i < 3; i++) begin
        sgn148_r[i] <= x147_r[i][63];
        mag148_r[i] <= x147_r[i][63] ? 62'(-x147_r[i]) : 62'(x147_r[i]);
      end
      r148_r <= r147_r;
      f148_r <= f147_r;
      e148_r <= e147_r;

      t149_r <= rt_c;
      r149_r <= r148_r;
      for (int i = 0; i < 3; i++) b149_r[i] <= -f148_r[i];
      e149_r <= e148_r;

      for (int j = 0; j < 9; j++) dp150_r[j] <= ax_c[j] * $signed(e149_r[j % 3]);
      r150_r <= r149_r;
      for (int i = 0; i < 3; i++) t150_r[i] <= t149_r[i][31:0];
      b150_r <= b149_r;

      for (int a = 0; a < 3; a++) begin
        dsum151_r[a] <= dp150_r[3*a] + dp150_r[3*a + 1] + dp150_r[3*a + 2];
      end
      r151_r <= r150_r;
      t151_r <= t150_r;
      b151_r <= b150_r;

      for (int a = 0; a < 3; a++) begin
        dsgn152_r[a] <= dsum151_r[a][63];
        dmag152_r[a] <= dsum151_r[a][63] ? 63'(-dsum151_r[a]) : 63'(dsum151_r[a]);
      end
      r152_r <= r151_r;
      t152_r <= t151_r;
      b152_r <= b151_r;

      sh153_r <= sh_c;
      r153_r  <= r152_r;
      t153_r  <= t152_r;
      b153_r  <= b152_r;
    end
  end

  lav_norm #(.VW(33)) u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vec_in   (d1_r),
    .axis_out (f72)
  );

  lav_delay #(.W(1 + 2 * $bits(vec3_t)), .DEPTH(NORM_LAT)) u_dly_fwd (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  ({v1_r, e1_r, u1_r}),
    .d_out ({v72, e72, u72})
  );

  lav_norm #(.VW(64)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vec_in   (c74_r),
    .axis_out (r145)
  );

  lav_delay #(.W(1 + 2 * $bits(vec3_t)), .DEPTH(NORM_LAT)) u_dly_right (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  ({v74_r, f74_r, e74_r}),
    .d_out ({v145, f145, e145})
  );

  assign out_valid       = v153_r;
  assign out_right_x     = r153_r[0];
  assign out_right_y     = r153_r[1];
  assign out_right_z     = r153_r[2];
  assign out_true_up_x   = t153_r[0];
  assign out_true_up_y   = t153_r[1];
  assign out_true_up_z   = t153_r[2];
  assign out_back_x      = b153_r[0];
  assign out_back_y      = b153_r[1];
  assign out_back_z      = b153_r[2];
  assign out_shift_right = sh153_r[0];
  assign out_shift_up    = sh153_r[1];
  assign out_shift_back  = sh153_r[2];

endmodule

/* rtl/core/lav_delay.sv */
// ----------------------------------------------------------------------------
// lav_delay
// Enabled shift line that keeps side data in step with a long datapath.
// ----------------------------------------------------------------------------
module lav_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] d_out
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) tap_r[i] <= '0;
    end else if (en) begin
      tap_r[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign d_out = tap_r[DEPTH-1];

endmodule

/* rtl/core/lav_isqrt.sv */
// ----------------------------------------------------------------------------
// lav_isqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module lav_isqrt
  import lav_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [SUMSQ_W-1:0] sum_in,
  output logic [ROOT_W-1:0]  root_out
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]   rem_r  [ROOT_W];
  logic [ROOT_W-1:0]  root_r [ROOT_W];
  logic [SUMSQ_W-1:0] rest_r [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W-1:0]   rem_in;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic [ROOT_W-1:0]  root_in;
    logic [SUMSQ_W-1:0] rest_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = sum_in;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rest_in = rest_r[j-1];
    end

    // bring down the next bit pair, try 4*root + 1
    assign rem_sh = {rem_in[REM_W-3:0], rest_in[SUMSQ_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[j]  <= rem_sh - trial;
          root_r[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= rem_sh;
          root_r[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rest_r[j] <= {rest_in[SUMSQ_W-3:0], 2'b00};
      end
    end
  end

  assign root_out = root_r[ROOT_W-1];

endmodule

/* rtl/core/lav_div3.sv */
// ----------------------------------------------------------------------------
// lav_div3
// Three-lane pipelined restoring divider with a shared divisor.
// ----------------------------------------------------------------------------
module lav_div3
  import lav_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [2:0][NUM_W-1:0]  num_in,
  input  logic [ROOT_W-1:0]      den_in,
  output logic [2:0][QUO_W-1:0]  quo_out
);

  logic [2:0][ROOT_W-1:0] rem_r [DIV_LAT];
  logic [2:0][QUO_W-1:0]  sr_r  [DIV_LAT];
  logic [ROOT_W-1:0]      den_r [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [2:0][ROOT_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0]  sr_in;
    logic [ROOT_W-1:0]      den;
    logic [2:0][ROOT_W:0]   part;
    logic [2:0][ROOT_W-1:0] rem_nxt;
    logic [2:0][QUO_W-1:0]  sr_nxt;

    if (k == 0) begin : g_first
      // quotient fits QUO_W bits, so the high dividend part is below the divisor
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = ROOT_W'(num_in[i][NUM_W-1:QUO_W]);
        assign sr_in[i]  = num_in[i][QUO_W-1:0];
      end
      assign den = den_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign sr_in  = sr_r[k-1];
      assign den    = den_r[k-1];
    end

    // shift the dividend out at the top, the quotient bit in at the bottom
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        part[i] = {rem_in[i], sr_in[i][QUO_W-1]};
        if (part[i] >= {1'b0, den}) begin
          rem_nxt[i] = ROOT_W'(part[i] - {1'b0, den});
          sr_nxt[i]  = {sr_in[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = part[i][ROOT_W-1:0];
          sr_nxt[i]  = {sr_in[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        sr_r[k]  <= sr_nxt;
        den_r[k] <= den;
      end
    end
  end

  assign quo_out = sr_r[DIV_LAT-1];

endmodule

/* rtl/core/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: common shift, sum of squares, square
// root, rounded divide. Output axes in Q2.30; a zero vector gives zero.
// ----------------------------------------------------------------------------
module lav_norm
  import lav_pkg::*;
#(
  parameter int VW = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [2:0][VW-1:0] vec_in,
  output vec3_t              axis_out
);

  localparam int NG  = (VW + 7) / 8;
  localparam int PW  = NG * 8;
  localparam int LZW = $clog2(PW);

  logic [2:0][VW-1:0]     mag1_r, mag2_r, mag3_r, mag4_r;
  logic [2:0]             sgn1_r, sgn2_r, sgn3_r, sgn4_r, sgn5_r, sgn6_r, sgn7_r;
  logic                   zero3_r, zero4_r, zero5_r, zero6_r, zero7_r;
  logic [VW-1:0]          mx2_r;
  logic [NG-1:0]          any3_r;
  logic [NG-1:0][2:0]     pos3_r;
  logic [LZW-1:0]         lz4_r;
  logic [2:0][MANT_W-1:0] m5_r, m6_r, m7_r;
  logic [2:0][SQ_W-1:0]   sq6_r;
  logic [SUMSQ_W-1:0]     sum7_r;
  logic [ROOT_W-1:0]      root;
  logic [2:0][MANT_W-1:0] m8;
  logic [2:0]             sgn8;
  logic                   zero8;
  logic [2:0]             sgn8_r;
  logic                   zero8_r;
  logic [2:0][NUM_W-1:0]  num8_r;
  logic [ROOT_W-1:0]      den8_r;
  logic [2:0][QUO_W-1:0]  quo;
  logic [2:0]             sgn9;
  logic                   zero9;
  vec3_t                  axis_r;

  logic [VW-1:0]          mx_c;
  logic [PW-1:0]          mxp_c;
  logic [NG-1:0]          any_c;
  logic [NG-1:0][2:0]     pos_c;
  logic [LZW-1:0]         lead_c;
  logic [2:0][MANT_W-1:0] m_c;
  logic [PW-1:0]          word_c [3];

  always_comb begin
    mx_c = mag1_r[0];
    if (mag1_r[1] > mx_c) mx_c = mag1_r[1];
    if (mag1_r[2] > mx_c) mx_c = mag1_r[2];
  end

  // leading one of the largest magnitude, per byte first
  always_comb begin
    mxp_c = PW'(mx2_r);
    for (int g = 0; g < NG; g++) begin
      any_c[g] = |mxp_c[g*8 +: 8];
      pos_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mxp_c[g*8+b]) pos_c[g] = 3'(b);
      end
    end
  end

  always_comb begin
    lead_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (any3_r[g]) lead_c = LZW'(g * 8 + int'(pos3_r[g]));
    end
  end

  // left-justify, keep the top bits: largest lands in [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      word_c[i] = PW'(mag4_r[i]) << lz4_r;
      m_c[i]    = word_c[i][PW-1 -: MANT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= vec_in[i][VW-1] ? VW'(-vec_in[i]) : vec_in[i];
        sgn1_r[i] <= vec_in[i][VW-1];
      end
      mag2_r  <= mag1_r;
      sgn2_r  <= sgn1_r;
      mx2_r   <= mx_c;
      mag3_r  <= mag2_r;
      sgn3_r  <= sgn2_r;
      zero3_r <= (mx2_r == '0);
      any3_r  <= any_c;
      pos3_r  <= pos_c;
      mag4_r  <= mag3_r;
      sgn4_r  <= sgn3_r;
      zero4_r <= zero3_r;
      lz4_r   <= LZW'(PW - 1) - lead_c;
      m5_r    <= m_c;
      sgn5_r  <= sgn4_r;
      zero5_r <= zero4_r;
      for (int i = 0; i < 3; i++) sq6_r[i] <= SQ_W'(m5_r[i]) * SQ_W'(m5_r[i]);
      m6_r    <= m5_r;
      sgn6_r  <= sgn5_r;
      zero6_r <= zero5_r;
      sum7_r  <= SUMSQ_W'(sq6_r[0]) + SUMSQ_W'(sq6_r[1]) + SUMSQ_W'(sq6_r[2]);
      m7_r    <= m6_r;
      sgn7_r  <= sgn6_r;
      zero7_r <= zero6_r;
      for (int i = 0; i < 3; i++) begin
        num8_r[i] <= NUM_W'({m8[i], {AXIS_FRAC{1'b0}}}) + NUM_W'(root >> 1);
      end
      den8_r  <= root;
      sgn8_r  <= sgn8;
      zero8_r <= zero8;
      for (int i = 0; i < 3; i++) begin
        if (zero9)        axis_r[i] <= '0;
        else if (sgn9[i]) axis_r[i] <= -(32'(quo[i]));
        else              axis_r[i] <= 32'(quo[i]);
      end
    end
  end

  lav_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .sum_in   (sum7_r),
    .root_out (root)
  );

  lav_delay #(.W(3 * MANT_W + 4), .DEPTH(SQRT_LAT)) u_dly_root (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  ({m7_r, sgn7_r, zero7_r}),
    .d_out ({m8, sgn8, zero8})
  );

  lav_div3 u_div (
    .clk     (clk),
    .en      (en),
    .num_in  (num8_r),
    .den_in  (den8_r),
    .quo_out (quo)
  );

  lav_delay #(.W(4), .DEPTH(DIV_LAT)) u_dly_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  ({sgn8_r, zero8_r}),
    .d_out ({sgn9, zero9})
  );

  assign axis_out = axis_r;

endmodule

/* tb/look_at_view_matrix_test.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_test
// Self-checking bench for the fixed-point look-at view matrix pipeline.
// ----------------------------------------------------------------------------
// Directed camera set-ups (degenerate axes, extreme coordinates, saturating
// translations) are followed by random ones. A local fixed-point model
// predicts every output row, and the monitor compares each output transaction
// with the oldest prediction. Random idle and stall bursts run on both sides.
// ----------------------------------------------------------------------------
module look_at_view_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 153;

  typedef struct {
    logic signed [31:0] eye[3];
    logic signed [31:0] aim[3];
    logic signed [31:0] upw[3];
  } camera_t;

  typedef struct {
    logic signed [31:0] v[12];
  } view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [31:0] in_aim_x = '0, in_aim_y = '0, in_aim_z = '0;
  logic signed [31:0] in_upward_x = '0, in_upward_y = '0, in_upward_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_right_x, out_right_y, out_right_z;
  logic signed [31:0] out_true_up_x, out_true_up_y, out_true_up_z;
  logic signed [31:0] out_back_x, out_back_y, out_back_z;
  logic signed [31:0] out_shift_right, out_shift_up, out_shift_back;

  camera_t pending_cams[$];
  view_t   expected_views[$];
  int      error_count = 0;
  bit      calm_phase = 1'b0;

  look_at_view_matrix i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input longint v[3], output longint o[3]);
    longint unsigned m[3];
    longint unsigned mx = 0, s = 0, n, q;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    n = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 30) + (n >> 1)) / n;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint round_q30(longint x);
    longint unsigned r = (mag64(x) + (64'd1 << 29)) >> 30;
    return x < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [31:0] translation(longint a[3], longint e[3]);
    longint t = -round_q30(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic view_t view_matrix(camera_t c);
    longint e[3], u[3], d[3], f[3], x[3], r[3], t[3], b[3];
    view_t res;
    for (int i = 0; i < 3; i++) begin
      e[i] = c.eye[i];
      u[i] = c.upw[i];
      d[i] = longint'(c.aim[i]) - e[i];
    end
    unit_vector(d, f);
    x[0] = f[1] * u[2] - f[2] * u[1];
    x[1] = f[2] * u[0] - f[0] * u[2];
    x[2] = f[0] * u[1] - f[1] * u[0];
    unit_vector(x, r);
    t[0] = round_q30(r[1] * f[2] - r[2] * f[1]);
    t[1] = round_q30(r[2] * f[0] - r[0] * f[2]);
    t[2] = round_q30(r[0] * f[1] - r[1] * f[0]);
    for (int i = 0; i < 3; i++) begin
      b[i] = -f[i];
      res.v[i] = r[i][31:0];
      res.v[3 + i] = t[i][31:0];
      res.v[6 + i] = b[i][31:0];
    end
    res.v[9] = translation(r, e);
    res.v[10] = translation(t, e);
    res.v[11] = translation(b, e);
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h3ff)) - 32'sh200;
    endcase
  endfunction

  function automatic camera_t rand_camera();
    camera_t c;
    int k = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = rand_coord($urandom_range(0, 9) == 0 ? 2 : k);
      c.aim[i] = rand_coord($urandom_range(0, 9) == 0 ? 2 : k);
      c.upw[i] = rand_coord($urandom_range(0, 3));
    end
    // occasionally collapse the forward or up axis
    case ($urandom_range(0, 11))
      0: c.aim = c.eye;
      1: for (int i = 0; i < 3; i++) c.upw[i] = c.aim[i] - c.eye[i];
      2: c.upw = '{0, 0, 0};
      default: ;
    endcase
    return c;
  endfunction

  function automatic camera_t make_camera(int ex, int ey, int ez, int ax, int ay,
                                          int az, int ux, int uy, int uz);
    camera_t c;
    c.eye = '{ex, ey, ez};
    c.aim = '{ax, ay, az};
    c.upw = '{ux, uy, uz};
    return c;
  endfunction

  initial begin
    localparam int ONE = 32'sh00010000;
    localparam int MX = 32'sh7fffffff;
    localparam int MN = 32'sh80000000;
    pending_cams.push_back(make_camera(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0));
    pending_cams.push_back(make_camera(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0));
    pending_cams.push_back(make_camera(0, 0, 0, 0, ONE, 0, 0, ONE, 0));
    pending_cams.push_back(make_camera(0, 0, 0, 0, 0, -ONE, 0, 0, 0));
    pending_cams.push_back(make_camera(MN, MN, MN, MX, MX, MX, 0, ONE, 0));
    pending_cams.push_back(make_camera(MX, MX, MX, MN, MN, MN, MN, MX, MN));
    pending_cams.push_back(make_camera(MX, MN, MX, 0, 0, 0, MX, MX, MX));
    pending_cams.push_back(make_camera(MN, MX, MN, MX, MN, MX, MN, MN, MN));
    pending_cams.push_back(make_camera(-1, -1, -1, 0, 0, 0, -1, 0, 1));
    pending_cams.push_back(make_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_cams.push_back(make_camera(MX, MX, MX, MX, MX, MN, 1, 0, 0));
    pending_cams.push_back(make_camera(MN, MN, MN, MN, MN, MN, MN, MN, MN));
    pending_cams.push_back(make_camera(3*ONE, -7*ONE, ONE, -ONE, 4*ONE, 9*ONE, ONE, ONE, 0));
    pending_cams.push_back(make_camera(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    repeat (500) pending_cams.push_back(rand_camera());
  end

  // Driver: present the next camera, idle in random bursts.
  int idle_in = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      // drop the accepted transaction, the head is now the next one to send
      if (in_valid && !in_stall) begin
        if (pending_cams.size() > 0) void'(pending_cams.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (idle_in > 0) begin
        idle_in <= idle_in - 1;
        in_valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
        idle_in <= $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pending_cams.size() > 0) begin
        camera_t c;
        c = pending_cams[0];
        in_valid <= 1'b1;
        {in_eye_x, in_eye_y, in_eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
        {in_aim_x, in_aim_y, in_aim_z} <= {c.aim[0], c.aim[1], c.aim[2]};
        {in_upward_x, in_upward_y, in_upward_z} <= {c.upw[0], c.upw[1], c.upw[2]};
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on acceptance.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      camera_t c;
      c.eye = '{in_eye_x, in_eye_y, in_eye_z};
      c.aim = '{in_aim_x, in_aim_y, in_aim_z};
      c.upw = '{in_upward_x, in_upward_y, in_upward_z};
      expected_views.push_back(view_matrix(c));
    end
  end

  // Monitor: compare accepted outputs, stall in random bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        logic signed [31:0] got[12];
        view_t exp_view;
        got = '{out_right_x, out_right_y, out_right_z, out_true_up_x, out_true_up_y,
                out_true_up_z, out_back_x, out_back_y, out_back_z, out_shift_right,
                out_shift_up, out_shift_back};
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected output transaction", $time);
          error_count++;
        end else begin
          exp_view = expected_views.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (got[i] !== exp_view.v[i]) begin
              $display("%0t: field %0d expected %0d actual %0d", $time, i,
                       exp_view.v[i], got[i]);
              error_count++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
        stall_left <= $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cams.size() < 60);
    calm_phase = 1'b1;
    wait (pending_cams.size() == 0 && !in_valid);
    wait (expected_views.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0 && expected_views.size() == 0) begin
      $display("PASS look_at_view_matrix");
    end else begin
      $display("FAIL look_at_view_matrix");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL look_at_view_matrix");
    $finish;
  end

endmodule
